>>> rtl/core/ddp_pkg.sv
`timescale 1ns / 1ps

package ddp_pkg;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] FIELD_DAY   = 2'd0;
    localparam logic [1:0] FIELD_MONTH = 2'd1;
    localparam logic [1:0] FIELD_YEAR  = 2'd2;

    localparam logic [1:0] STATUS_OK            = 2'd0;
    localparam logic [1:0] STATUS_FIRST_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FINAL_INVALID = 2'd2;
    localparam logic [1:0] STATUS_OUT_OF_ORDER  = 2'd3;

    localparam int YEAR_W = 14;

    // One finished date as handed from the parser to the difference stage.
    typedef struct packed {
        logic              sel;
        logic              ok;
        logic              leap;
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
    } ddp_date_t;

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/core/ddp_channels.sv
`timescale 1ns / 1ps

interface ddp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       date_select;
    logic       end_of_date;

    modport source (output valid, char_code, date_select, end_of_date, input ready);
    modport sink   (input valid, char_code, date_select, end_of_date, output ready);
endinterface

interface ddp_result_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [13:0]       diff_years;
    logic [3:0]        diff_months;
    logic signed [5:0] diff_days;

    modport source (output valid, status, diff_years, diff_months, diff_days, input ready);
    modport sink   (input valid, status, diff_years, diff_months, diff_days, output ready);
endinterface

>>> rtl/core/ddp_front.sv
`timescale 1ns / 1ps

module ddp_front
    import ddp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ddp_char_if.sink   chars,
    input  logic       queue_full,
    output logic       push,
    output ddp_date_t  push_date
);

    logic [1:0]        field_reg,  field_next;
    logic [2:0]        count_reg,  count_next;
    logic [6:0]        day_reg,    day_next;
    logic [6:0]        month_reg,  month_next;
    logic [YEAR_W-1:0] year_reg,   year_next;
    logic [4:0]        rem25_reg,  rem25_next;
    logic              ok_reg,     ok_next;

    logic              accept;
    logic              is_digit;
    logic [3:0]        digit;
    logic [2:0]        limit;
    logic [YEAR_W-1:0] year_full;
    logic              leap;
    logic              date_ok;

    // Remainder by 25 of a value below 250, via a reciprocal multiply.
    function automatic logic [4:0] mod25(input logic [7:0] v);
        logic [13:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        prod = 14'(v) * 14'd41;
        q    = prod[13:10];
        r    = v - 8'(q * 5'd25);
        return r[4:0];
    endfunction

    assign chars.ready = !queue_full;
    assign accept      = chars.valid && !queue_full;
    assign is_digit    = (chars.char_code >= CHAR_ZERO) && (chars.char_code <= CHAR_NINE);
    assign digit       = 4'(chars.char_code - CHAR_ZERO);
    assign limit       = (field_reg == FIELD_YEAR) ? 3'd4 : 3'd2;

    always_comb
    begin
        field_next = field_reg;
        count_next = count_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        rem25_next = rem25_reg;
        ok_next    = ok_reg;
        if (chars.char_code == CHAR_SLASH) begin
            if (field_reg != FIELD_YEAR) begin
                if (count_reg == 3'd0) begin
                    ok_next = 1'b0;
                end
                field_next = field_reg + 2'd1;
                count_next = 3'd0;
            end else begin
                ok_next = 1'b0;
            end
        end else if (is_digit) begin
            if (count_reg < limit) begin
                case (field_reg)
                    FIELD_DAY:   day_next = 7'({day_reg, 3'b0} + {day_reg, 1'b0} + 7'(digit));
                    FIELD_MONTH: month_next = 7'({month_reg, 3'b0} + {month_reg, 1'b0}
                                                 + 7'(digit));
                    default:
                    begin
                        year_next  = YEAR_W'({year_reg, 3'b0} + {year_reg, 1'b0}
                                             + YEAR_W'(digit));
                        rem25_next = mod25(8'({rem25_reg, 3'b0} + {rem25_reg, 1'b0})
                                           + 8'(digit));
                    end
                endcase
                count_next = count_reg + 3'd1;
            end else begin
                ok_next = 1'b0;
            end
        end else begin
            ok_next = 1'b0;
        end
    end

    // A two-digit year lies in this century; 2000 is a multiple of 16 and 25,
    // so the running remainder by 25 still holds for the full year.
    assign year_full = (count_next == 3'd2) ? year_next + YEAR_W'(2000) : year_next;
    assign leap = ((year_full[3:0] == 4'd0) && (rem25_next == 5'd0))
               || ((year_full[1:0] == 2'd0) && (rem25_next != 5'd0));

    always_comb
    begin
        date_ok = ok_next && (field_next == FIELD_YEAR)
               && ((count_next == 3'd2) || (count_next == 3'd4));
        if ((month_next < 7'd1) || (month_next > 7'd12)) begin
            date_ok = 1'b0;
        end else if ((day_next < 7'd1)
                  || (day_next > 7'(month_length(month_next[3:0], leap)))) begin
            date_ok = 1'b0;
        end
    end

    assign push           = accept && chars.end_of_date;
    assign push_date.sel   = chars.date_select;
    assign push_date.ok    = date_ok;
    assign push_date.leap  = leap;
    assign push_date.day   = day_next[4:0];
    assign push_date.month = month_next[3:0];
    assign push_date.year  = year_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            field_reg <= FIELD_DAY;
            count_reg <= 3'd0;
            day_reg   <= 7'd0;
            month_reg <= 7'd0;
            year_reg  <= '0;
            rem25_reg <= 5'd0;
            ok_reg    <= 1'b1;
        end else if (accept) begin
            if (chars.end_of_date) begin
                field_reg <= FIELD_DAY;
                count_reg <= 3'd0;
                day_reg   <= 7'd0;
                month_reg <= 7'd0;
                year_reg  <= '0;
                rem25_reg <= 5'd0;
                ok_reg    <= 1'b1;
            end else begin
                field_reg <= field_next;
                count_reg <= count_next;
                day_reg   <= day_next;
                month_reg <= month_next;
                year_reg  <= year_next;
                rem25_reg <= rem25_next;
                ok_reg    <= ok_next;
            end
        end
    end

endmodule

>>> rtl/core/ddp_queue.sv
`timescale 1ns / 1ps

module ddp_queue
    import ddp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ddp_date_t push_date,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output ddp_date_t head_date
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ddp_date_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_date  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_date;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/ddp_back.sv
`timescale 1ns / 1ps

module ddp_back
    import ddp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  ddp_date_t   head_date,
    output logic        pop,
    ddp_result_if.source results
);

    logic              first_ok_reg;
    logic [4:0]        first_day_reg;
    logic [3:0]        first_month_reg;
    logic [YEAR_W-1:0] first_year_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg,  status_next;
    logic [13:0]       years_reg,   years_next;
    logic [3:0]        months_reg,  months_next;
    logic [5:0]        days_reg,    days_next;

    logic              out_free;
    logic              later;
    logic [3:0]        prev_month;
    logic signed [6:0] days_raw;
    logic signed [6:0] days_adj;
    logic signed [4:0] months_raw;
    logic signed [4:0] months_adj;
    logic [YEAR_W-1:0] years_raw;

    assign out_free = !out_valid_reg || results.ready;
    // An initial date only updates the latched copy, so it never waits on the output.
    assign pop      = head_valid && (!head_date.sel || out_free);

    assign later = (first_year_reg > head_date.year)
                || ((first_year_reg == head_date.year) && (first_month_reg > head_date.month))
                || ((first_year_reg == head_date.year) && (first_month_reg == head_date.month)
                    && (first_day_reg > head_date.day));

    assign prev_month = (head_date.month == 4'd1) ? 4'd12 : head_date.month - 4'd1;
    assign days_raw   = signed'(7'(head_date.day)) - signed'(7'(first_day_reg));
    assign months_raw = signed'(5'(head_date.month)) - signed'(5'(first_month_reg));
    assign years_raw  = head_date.year - first_year_reg;

    always_comb
    begin
        days_adj   = days_raw;
        months_adj = months_raw;
        years_next = years_raw;
        if (days_raw < 0) begin
            days_adj   = days_raw + signed'(7'(month_length(prev_month, head_date.leap)));
            months_adj = months_raw - 5'sd1;
        end
        if (months_adj < 0) begin
            months_adj = months_adj + 5'sd12;
            years_next = years_raw - 14'd1;
        end
        months_next = months_adj[3:0];
        days_next   = days_adj[5:0];
        if (!first_ok_reg) begin
            status_next = STATUS_FIRST_INVALID;
        end else if (!head_date.ok) begin
            status_next = STATUS_FINAL_INVALID;
        end else if (later) begin
            status_next = STATUS_OUT_OF_ORDER;
        end else begin
            status_next = STATUS_OK;
        end
        if (status_next != STATUS_OK) begin
            years_next  = '0;
            months_next = '0;
            days_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            first_ok_reg    <= 1'b0;
            first_day_reg   <= '0;
            first_month_reg <= '0;
            first_year_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (pop && !head_date.sel) begin
                first_ok_reg    <= head_date.ok;
                first_day_reg   <= head_date.day;
                first_month_reg <= head_date.month;
                first_year_reg  <= head_date.year;
            end
            if (pop && head_date.sel) begin
                out_valid_reg <= 1'b1;
            end else if (results.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_date.sel) begin
            status_reg <= status_next;
            years_reg  <= years_next;
            months_reg <= months_next;
            days_reg   <= days_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = status_reg;
    assign results.diff_years  = years_reg;
    assign results.diff_months = months_reg;
    assign results.diff_days   = signed'(days_reg);

endmodule

>>> rtl/core/date_difference_parser_unit.sv
`timescale 1ns / 1ps
// Date validation and difference unit.
// The chars channel carries one ASCII character per transfer, dates written
// d/m/y, with date_select telling initial (0) from final (1) and end_of_date
// marking the last character. The results channel carries one result per final
// date: a status and, when the status is ok, the difference in years, months
// and days. An initial date produces no result; it is latched and kept for all
// following final dates until the next initial date ends.
// Throughput is one character per cycle while the date queue is not full.
// A final date is parsed and validated into the date queue as its last
// character transfers; the difference stage loads the result register once
// the date is at the head of the queue and the output can take it.
// The date queue holds FIFO_DEPTH finished dates. When the receiver stalls, the
// result register holds its value and the queue fills; chars.ready drops only
// when the queue is full.
// Reset clears the parser, empties the queue and the result register, and
// marks the latched initial date invalid.
module date_difference_parser_unit
    import ddp_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    ddp_char_if.sink     chars,
    ddp_result_if.source results
);

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      head_valid;
    ddp_date_t push_date;
    ddp_date_t head_date;

    ddp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .queue_full (queue_full),
        .push       (push),
        .push_date  (push_date)
    );

    ddp_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_date  (push_date),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_date  (head_date)
    );

    ddp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_date  (head_date),
        .pop        (pop),
        .results    (results)
    );

endmodule

>>> test/ddp_result_checker.sv
`timescale 1ns / 1ps

module ddp_result_checker
    import ddp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ddp_char_if   chars,
    ddp_result_if results,
    output int    mismatch_count,
    output int    pending_count
);

    typedef struct {
        logic [1:0]        status;
        logic [13:0]       years;
        logic [3:0]        months;
        logic signed [5:0] days;
    } date_diff_t;

    // Parser of the date being received.
    logic [1:0]  field_sel;
    logic [2:0]  digit_cnt;
    logic [6:0]  day_acc;
    logic [6:0]  month_acc;
    logic [13:0] year_acc;
    logic        text_ok;

    // Latched initial date.
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic        start_ok;

    date_diff_t  expected_diffs[$];

    initial
    begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    function automatic bit leap_year(input int year);
        return (year % 400 == 0) || (year % 4 == 0 && year % 100 != 0);
    endfunction

    function automatic int days_in_month(input int month, input int year);
        case (month)
            2:           return leap_year(year) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    task automatic clear_parser();
        field_sel = FIELD_DAY;
        digit_cnt = 3'd0;
        day_acc   = 7'd0;
        month_acc = 7'd0;
        year_acc  = 14'd0;
        text_ok   = 1'b1;
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic absorb_char(input logic [7:0] code, input logic sel, input logic last);
        int         digit;
        int         limit;
        int         year;
        int         month;
        int         day;
        int         d_years;
        int         d_months;
        int         d_days;
        logic       ok;
        date_diff_t diff;
        if (code == CHAR_SLASH)
        begin
            if (field_sel != FIELD_YEAR)
            begin
                if (digit_cnt == 3'd0)
                    text_ok = 1'b0;
                field_sel = field_sel + 2'd1;
                digit_cnt = 3'd0;
            end
            else
            begin
                text_ok = 1'b0;
            end
        end
        else if (code >= CHAR_ZERO && code <= CHAR_NINE)
        begin
            digit = int'(code - CHAR_ZERO);
            limit = (field_sel == FIELD_YEAR) ? 4 : 2;
            if (digit_cnt < limit)
            begin
                case (field_sel)
                    FIELD_DAY:   day_acc   = 7'(day_acc * 10 + digit);
                    FIELD_MONTH: month_acc = 7'(month_acc * 10 + digit);
                    default:     year_acc  = 14'(year_acc * 10 + digit);
                endcase
                digit_cnt = digit_cnt + 3'd1;
            end
            else
            begin
                text_ok = 1'b0;
            end
        end
        else
        begin
            text_ok = 1'b0;
        end

        if (!last)
            return;

        ok    = text_ok && field_sel == FIELD_YEAR && (digit_cnt == 3'd2 || digit_cnt == 3'd4);
        year  = (digit_cnt == 3'd2) ? int'(year_acc) + 2000 : int'(year_acc);
        month = int'(month_acc);
        day   = int'(day_acc);
        if (month < 1 || month > 12)
            ok = 1'b0;
        else if (day < 1 || day > days_in_month(month, year))
            ok = 1'b0;
        clear_parser();

        if (!sel)
        begin
            start_ok    = ok;
            start_day   = 5'(day);
            start_month = 4'(month);
            start_year  = 14'(year);
            return;
        end

        d_years     = 0;
        d_months    = 0;
        d_days      = 0;
        diff.status = STATUS_OK;
        if (!start_ok)
        begin
            diff.status = STATUS_FIRST_INVALID;
        end
        else if (!ok)
        begin
            diff.status = STATUS_FINAL_INVALID;
        end
        else if (int'(start_year) > year ||
                 (int'(start_year) == year && int'(start_month) > month) ||
                 (int'(start_year) == year && int'(start_month) == month &&
                  int'(start_day) > day))
        begin
            diff.status = STATUS_OUT_OF_ORDER;
        end
        else
        begin
            d_days   = day - int'(start_day);
            d_months = month - int'(start_month);
            d_years  = year - int'(start_year);
            // The borrowed month is the one before the final month, in the final year.
            if (d_days < 0)
            begin
                d_months -= 1;
                d_days   += days_in_month((month + 10) % 12 + 1, year);
            end
            if (d_months < 0)
            begin
                d_years  -= 1;
                d_months += 12;
            end
        end
        diff.years  = 14'(d_years);
        diff.months = 4'(d_months);
        diff.days   = 6'(d_days);
        expected_diffs.push_back(diff);
    endtask

    task automatic check_result();
        date_diff_t want;
        if (expected_diffs.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result transfer, status %0d", results.status));
            return;
        end
        want = expected_diffs.pop_front();
        if (results.status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      results.status, want.status));
        if (results.diff_years !== want.years)
            report_mismatch($sformatf("diff_years got %0d, expected %0d",
                                      results.diff_years, want.years));
        if (results.diff_months !== want.months)
            report_mismatch($sformatf("diff_months got %0d, expected %0d",
                                      results.diff_months, want.months));
        if (results.diff_days !== want.days)
            report_mismatch($sformatf("diff_days got %0d, expected %0d",
                                      results.diff_days, want.days));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            start_day   = 5'd0;
            start_month = 4'd0;
            start_year  = 14'd0;
            start_ok    = 1'b0;
            expected_diffs.delete();
            pending_count <= 0;
        end
        else
        begin
            // A result never transfers in the same cycle as its final character.
            if (results.valid && results.ready)
                check_result();
            if (chars.valid && chars.ready)
                absorb_char(chars.char_code, chars.date_select, chars.end_of_date);
            pending_count <= expected_diffs.size();
        end
    end

endmodule

>>> test/date_difference_parser_unit_test.sv
`timescale 1ns / 1ps

module date_difference_parser_unit_test
    import ddp_pkg::*;
();

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    logic       clk = 1'b0;
    logic       rst_n;
    int         sender_idle_pct;
    int         receiver_idle_pct;
    int         chars_sent = 0;
    int         quiet_cycles;
    int         mismatch_count;
    int         pending_count;
    logic [7:0] date_text[$];

    ddp_char_if   chars();
    ddp_result_if results();

    date_difference_parser_unit i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    ddp_result_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .chars          (chars),
        .results        (results),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        results.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic put_char(input logic [7:0] code, input logic sel, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid       <= 1'b1;
        chars.char_code   <= code;
        chars.date_select <= sel;
        chars.end_of_date <= last;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    // The select bit only matters on the last character, so the others get noise.
    task automatic send_date(input logic sel);
        int n;
        n = date_text.size();
        for (int i = 0; i < n; i++)
            put_char(date_text[i], (i == n - 1) ? sel : 1'($urandom_range(1)), i == n - 1);
        date_text.delete();
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            date_text.push_back(s[i]);
    endtask

    task automatic send_literal(input string s, input logic sel);
        append_text(s);
        send_date(sel);
    endtask

    // Mostly well-formed dates with random content; some noise and damaged text.
    task automatic compose_date();
        string digit_chars = "0123456789/";
        int    day;
        int    month;
        int    kind;
        int    pos;
        date_text.delete();
        if ($urandom_range(99) < 6)
        begin
            repeat ($urandom_range(8, 1))
            begin
                if ($urandom_range(1) == 1)
                    date_text.push_back(8'($urandom_range(255)));
                else
                    date_text.push_back(digit_chars[$urandom_range(10)]);
            end
            return;
        end
        month = ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(12, 1);
        day   = ($urandom_range(19) == 0) ? $urandom_range(99) : $urandom_range(31, 1);
        if (day < 10 && $urandom_range(1) == 1)
            append_text($sformatf("%02d", day));
        else
            append_text($sformatf("%0d", day));
        date_text.push_back(CHAR_SLASH);
        if (month < 10 && $urandom_range(1) == 1)
            append_text($sformatf("%02d", month));
        else
            append_text($sformatf("%0d", month));
        date_text.push_back(CHAR_SLASH);
        kind = $urandom_range(99);
        if (kind < 40)
            append_text($sformatf("%02d", $urandom_range(99)));
        else if (kind < 85)
            append_text($sformatf("%04d", $urandom_range(2030, 1990)));
        else if (kind < 95)
            append_text($sformatf("%04d", $urandom_range(9999)));
        else
        begin
            case ($urandom_range(2))
                0:       append_text($sformatf("%0d", $urandom_range(9)));
                1:       append_text($sformatf("%03d", $urandom_range(999)));
                default: append_text($sformatf("%05d", $urandom_range(99999)));
            endcase
        end
        if ($urandom_range(14) == 0)
        begin
            pos = $urandom_range(date_text.size() - 1);
            case ($urandom_range(2))
                0:       date_text[pos] = 8'($urandom_range(255));
                1:       date_text.insert(pos, CHAR_SLASH);
                default: date_text.delete(pos);
            endcase
        end
    endtask

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((chars.valid && chars.ready) || (results.valid && results.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int phase_goal;
        rst_n             = 1'b0;
        sender_idle_pct   = 38;
        receiver_idle_pct = 77;
        chars.valid       <= 1'b0;
        chars.char_code   <= 8'd0;
        chars.date_select <= 1'b0;
        chars.end_of_date <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A final date before any initial date has ended.
        send_literal("1/1/00", 1'b1);
        send_literal("29/2/2000", 1'b0);
        send_literal("1/3/2000", 1'b1);
        send_literal("28/2/2000", 1'b1);
        send_literal("29/2/1900", 1'b1);
        send_literal("29/2/2024", 1'b1);
        // Initial invalid wins over final invalid.
        send_literal("0/1/2020", 1'b0);
        send_literal("1x/1/2020", 1'b1);
        // Widest difference.
        send_literal("1/1/0000", 1'b0);
        send_literal("31/12/9999", 1'b1);
        send_literal("1/1/20/", 1'b1);
        send_literal("/1/2020", 1'b1);
        send_literal("1/123/2020", 1'b1);
        send_literal("1/1/20201", 1'b1);
        send_literal("1/1/202", 1'b1);
        // A borrow from a short February leaves the days negative.
        send_literal("31/1/2021", 1'b0);
        send_literal("1/3/2021", 1'b1);
        send_literal("15/13/2021", 1'b1);
        send_literal("31/4/2021", 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 38;
                    receiver_idle_pct = 77;
                end
                1:
                begin
                    sender_idle_pct   = 77;
                    receiver_idle_pct = 38;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            phase_goal = chars_sent + RANDOM_ITEMS / 3;
            while (chars_sent < phase_goal)
            begin
                compose_date();
                send_date($urandom_range(3) != 0);
            end
            // Hold the sender until every result of this phase has come out.
            chars.valid <= 1'b0;
            @(posedge clk);
            while (pending_count != 0)
                @(posedge clk);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
